// ===== src/sds_pkg.sv =====
`timescale 1ns / 1ps

package sds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_W      = 16;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TRACKS_W     = TRACK_W + 1;
  localparam int SEEK_W       = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  localparam logic [SEEK_W-1:0]    SEEK_MAX = {SEEK_W{1'b1}};
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(MAX_REQUESTS);

  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_TRACKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT = 2'd2;

  typedef enum logic [1:0] {
    SEL_HEAD  = 2'd0,
    SEL_STORE = 2'd1,
    SEL_EDGE  = 2'd2
  } pos_sel_e;

  typedef struct packed {
    logic     insert;
    logic     step;
    logic     run_down;
    logic     latch_split;
    logic     idx_to_split;
    logic     emit;
    pos_sel_e sel;
    logic     last;
    logic     clear_batch;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic run_empty;
    logic run_last;
    logic out_free;
    logic split_zero;
    logic split_full;
    logic sweep_right;
  } status_t;

endpackage

// ===== src/sds_datapath.sv =====
`timescale 1ns / 1ps

module sds_datapath
  import sds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [TRACK_W-1:0]    track_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TRACK_W-1:0]    position_o,
  output logic [SEEK_W-1:0]     total_seek_o,
  output logic                  end_of_sequence_o,
  output logic                  overflowed_o
);

  logic [TRACK_W-1:0]  start_head_q;
  logic [TRACKS_W-1:0] disk_tracks_q;
  logic                sweep_right_q;

  logic [TRACK_W-1:0]  store_q [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gt;
  logic [CNT_W-1:0]    count_q;
  logic                drop_q;
  logic [CNT_W-1:0]    idx_q;
  logic [CNT_W-1:0]    split_q;
  logic [TRACK_W-1:0]  cur_q;
  logic [SEEK_W-1:0]   seek_q;

  logic                out_valid_q;
  logic [TRACK_W-1:0]  position_q;
  logic [SEEK_W-1:0]   total_q;
  logic                eos_q;
  logic                ovf_q;

  logic [CNT_W-1:0]    rd_idx;
  logic [TRACK_W-1:0]  rd_data;
  logic [TRACK_W-1:0]  edge_pos;
  logic [TRACK_W-1:0]  pos_d;
  logic [TRACK_W-1:0]  step_dist;
  logic [SEEK_W:0]     sum;
  logic [SEEK_W-1:0]   total_d;
  logic                full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q  <= '0;
      disk_tracks_q <= TRACKS_W'(1 << TRACK_W);
      sweep_right_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_HEAD:  start_head_q  <= cfg_data_i[TRACK_W-1:0];
        REG_DISK_TRACKS: disk_tracks_q <= cfg_data_i[TRACKS_W-1:0];
        REG_SWEEP_RIGHT: sweep_right_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign full = (count_q >= CNT_FULL);

  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = (CNT_W'(i) < count_q) && (store_q[i] > track_i);
    end
  end

  // Ordered insertion: every entry above the new track moves up by one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
        if (gt[i] || (CNT_W'(i) == count_q)) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
          end else begin
            store_q[i] <= track_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      idx_q   <= '0;
      split_q <= '0;
    end else begin
      if (cmd_i.clear_batch) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else if (cmd_i.insert) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.insert) begin
        idx_q <= '0;
      end else if (cmd_i.idx_to_split) begin
        idx_q <= split_q;
      end else if (cmd_i.step) begin
        idx_q <= cmd_i.run_down ? idx_q - 1'b1 : idx_q + 1'b1;
      end
      if (cmd_i.latch_split) begin
        split_q <= idx_q;
      end
    end
  end

  assign rd_idx  = cmd_i.run_down ? idx_q - 1'b1 : idx_q;
  assign rd_data = store_q[rd_idx[IDX_W-1:0]];

  always_comb begin
    if (disk_tracks_q == '0) begin
      edge_pos = '0;
    end else if (disk_tracks_q[TRACKS_W-1]) begin
      edge_pos = {TRACK_W{1'b1}};
    end else begin
      edge_pos = disk_tracks_q[TRACK_W-1:0] - 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HEAD:  pos_d = start_head_q;
      SEL_STORE: pos_d = rd_data;
      SEL_EDGE:  pos_d = sweep_right_q ? edge_pos : '0;
      default:   pos_d = start_head_q;
    endcase
  end

  assign step_dist = (pos_d >= cur_q) ? pos_d - cur_q : cur_q - pos_d;
  assign sum       = {1'b0, seek_q} + {{(SEEK_W + 1 - TRACK_W){1'b0}}, step_dist};

  always_comb begin
    if (cmd_i.sel == SEL_HEAD) begin
      total_d = '0;
    end else if (sum[SEEK_W]) begin
      total_d = SEEK_MAX;
    end else begin
      total_d = sum[SEEK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      seek_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        cur_q       <= pos_d;
        seek_q      <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      position_q <= pos_d;
      total_q    <= total_d;
      eos_q      <= cmd_i.last;
      ovf_q      <= drop_q;
    end
  end

  assign status_o.scan_hit    = (idx_q == count_q) || (rd_data >= start_head_q);
  assign status_o.run_empty   = cmd_i.run_down ? (idx_q == '0) : (idx_q == count_q);
  assign status_o.run_last    = cmd_i.run_down ? (idx_q == CNT_W'(1))
                                               : ({1'b0, idx_q} + 1'b1 == {1'b0, count_q});
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.split_zero  = (split_q == '0);
  assign status_o.split_full  = (split_q == count_q);
  assign status_o.sweep_right = sweep_right_q;

  assign out_valid_o       = out_valid_q;
  assign position_o        = position_q;
  assign total_seek_o      = total_q;
  assign end_of_sequence_o = eos_q;
  assign overflowed_o      = ovf_q;

endmodule

// ===== src/sds_ctrl.sv =====
`timescale 1ns / 1ps

module sds_ctrl
  import sds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    final_request_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_HEAD = 6'b000100,
    S_RUN1 = 6'b001000,
    S_EDGE = 6'b010000,
    S_RUN2 = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_STORE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          if (final_request_i) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (status_i.scan_hit) begin
          cmd_o.latch_split = 1'b1;
          state_d = S_HEAD;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd_o.sel = SEL_HEAD;
        if (status_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.idx_to_split = 1'b1;
          state_d = S_RUN1;
        end
      end
      S_RUN1: begin
        cmd_o.run_down = !status_i.sweep_right;
        if (status_i.run_empty) begin
          state_d = S_EDGE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
        end
      end
      S_EDGE: begin
        cmd_o.sel = SEL_EDGE;
        if (status_i.out_free) begin
          cmd_o.emit         = 1'b1;
          cmd_o.last         = status_i.sweep_right ? status_i.split_zero
                                                    : status_i.split_full;
          cmd_o.idx_to_split = 1'b1;
          state_d = S_RUN2;
        end
      end
      S_RUN2: begin
        cmd_o.run_down = status_i.sweep_right;
        if (status_i.run_empty) begin
          cmd_o.clear_batch = 1'b1;
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
          cmd_o.last = status_i.run_last;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/scan_disk_scheduler.sv =====
`timescale 1ns / 1ps

// SCAN disk scheduler. Track requests arrive on the input channel one per
// cycle and are inserted in ascending order into a store of MAX_REQUESTS
// entries; requests beyond capacity are dropped and flagged in overflowed_o.
// The request with final_request_i set starts emission, and the input channel
// stays not ready until the whole sequence has been handed to the output
// register. A scan over the sorted store finds the first request at or above
// the start head. Results then leave at one per cycle while the receiver
// takes them: the start head, the first sweep, the disk edge and the return
// sweep, with a step that gives no result at the end of each sweep.
// Configuration writes are always accepted and should only be made while the
// block is idle. Reset clears the batch and sets start head 0, 65536 tracks
// and a rightward first sweep. When the receiver stalls, the output register
// holds its result and the sequencer waits without losing a position.

module scan_disk_scheduler
  import sds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TRACK_W-1:0]    track_i,
  input  logic                  final_request_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TRACK_W-1:0]    position_o,
  output logic [SEEK_W-1:0]     total_seek_o,
  output logic                  end_of_sequence_o,
  output logic                  overflowed_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sds_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .final_request_i (final_request_i),
    .in_ready_o      (in_ready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  sds_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .track_i           (track_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_o        (position_o),
    .total_seek_o      (total_seek_o),
    .end_of_sequence_o (end_of_sequence_o),
    .overflowed_o      (overflowed_o)
  );

endmodule

// ===== tb/scan_seek_predictor.sv =====
`timescale 1ns / 1ps

module scan_seek_predictor
  import sds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [TRACK_W-1:0]    track_i,
  input  logic                  final_request_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [TRACK_W-1:0]    position_i,
  input  logic [SEEK_W-1:0]     total_seek_i,
  input  logic                  end_of_sequence_i,
  input  logic                  overflowed_i,
  output int                    stops_waiting_o,
  output int                    mismatches_o
);

  typedef struct packed {
    logic [TRACK_W-1:0] position;
    logic [SEEK_W-1:0]  total_seek;
    logic               end_of_sequence;
    logic               overflowed;
  } seek_stop_t;

  logic [TRACK_W-1:0]  sorted_tracks[$];
  logic                batch_dropped;
  logic [TRACK_W-1:0]  head_cfg;
  logic [TRACKS_W-1:0] tracks_cfg;
  logic                sweep_right_cfg;
  int unsigned         plan_head;
  int unsigned         plan_seek;
  seek_stop_t          expected_stops[$];

  // Moves the predicted head and queues the result that the move produces.
  function automatic void add_stop(input int unsigned pos, input bit last);
    seek_stop_t stop;
    int unsigned step_dist;
    step_dist = (pos > plan_head) ? pos - plan_head : plan_head - pos;
    plan_seek = plan_seek + step_dist;
    if (plan_seek > SEEK_MAX) plan_seek = SEEK_MAX;
    plan_head = pos;
    stop.position        = TRACK_W'(pos);
    stop.total_seek      = SEEK_W'(plan_seek);
    stop.end_of_sequence = last;
    stop.overflowed      = batch_dropped;
    expected_stops.push_back(stop);
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seek_stop_t  want;
    int          i;
    int          n;
    int          split;
    int unsigned tracks;
    int unsigned edge_pos;
    if (!rst_ni) begin
      sorted_tracks.delete();
      expected_stops.delete();
      batch_dropped   = 1'b0;
      head_cfg        = '0;
      tracks_cfg      = TRACKS_W'(65536);
      sweep_right_cfg = 1'b1;
      plan_head       = 0;
      plan_seek       = 0;
      stops_waiting_o = 0;
      mismatches_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_stops.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual position %0d seek %0d",
                   $time, position_i, total_seek_i);
          mismatches_o++;
        end else begin
          want = expected_stops.pop_front();
          compare_field("position", want.position, position_i);
          compare_field("total_seek", want.total_seek, total_seek_i);
          compare_field("end_of_sequence", want.end_of_sequence, end_of_sequence_i);
          compare_field("overflowed", want.overflowed, overflowed_i);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_START_HEAD:  head_cfg = cfg_data_i[TRACK_W-1:0];
          REG_DISK_TRACKS: tracks_cfg = cfg_data_i[TRACKS_W-1:0];
          REG_SWEEP_RIGHT: sweep_right_cfg = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (sorted_tracks.size() >= MAX_REQUESTS) begin
          batch_dropped = 1'b1;
        end else begin
          i = sorted_tracks.size();
          while (i > 0 && sorted_tracks[i-1] > track_i) i--;
          sorted_tracks.insert(i, track_i);
        end

        if (final_request_i) begin
          n        = sorted_tracks.size();
          tracks   = (tracks_cfg == 0) ? 1 : tracks_cfg;
          edge_pos = tracks - 1;
          if (edge_pos > (1 << TRACK_W) - 1) edge_pos = (1 << TRACK_W) - 1;
          plan_head = head_cfg;
          plan_seek = 0;

          // When every request lies below the head, the split sits past the end.
          split = n;
          for (i = 0; i < n; i++) begin
            if (sorted_tracks[i] >= plan_head) begin
              split = i;
              break;
            end
          end

          add_stop(plan_head, 1'b0);
          if (sweep_right_cfg) begin
            for (i = split; i < n; i++) add_stop(sorted_tracks[i], 1'b0);
            add_stop(edge_pos, split == 0);
            for (i = split; i > 0; i--) add_stop(sorted_tracks[i-1], i == 1);
          end else begin
            for (i = split; i > 0; i--) add_stop(sorted_tracks[i-1], 1'b0);
            add_stop(0, split >= n);
            for (i = split; i < n; i++) add_stop(sorted_tracks[i], i + 1 == n);
          end

          sorted_tracks.delete();
          batch_dropped = 1'b0;
          plan_seek     = 0;
        end
      end

      stops_waiting_o = expected_stops.size();
    end
  end

endmodule

// ===== tb/scan_disk_scheduler_test.sv =====
`timescale 1ns / 1ps

module scan_disk_scheduler_test;
  import sds_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 154;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TRACK_W-1:0]    track = '0;
  logic                  final_request = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TRACK_W-1:0]    position;
  logic [SEEK_W-1:0]     total_seek;
  logic                  end_of_sequence;
  logic                  overflowed;

  int                    stops_waiting;
  int                    mismatches;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  int                    hold_req = 0;
  int                    hold_done = 0;
  int                    items_sent = 0;
  logic [TRACK_W-1:0]    cur_head = '0;

  always #2 clk = ~clk;

  scan_disk_scheduler u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .track_i           (track),
    .final_request_i   (final_request),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .position_o        (position),
    .total_seek_o      (total_seek),
    .end_of_sequence_o (end_of_sequence),
    .overflowed_o      (overflowed)
  );

  scan_seek_predictor u_seek_predictor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .track_i           (track),
    .final_request_i   (final_request),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .position_i        (position),
    .total_seek_i      (total_seek),
    .end_of_sequence_i (end_of_sequence),
    .overflowed_i      (overflowed),
    .stops_waiting_o   (stops_waiting),
    .mismatches_o      (mismatches)
  );

  task automatic send_request(input logic [TRACK_W-1:0] t, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    track         <= t;
    final_request <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_START_HEAD) cur_head = data[TRACK_W-1:0];
  endtask

  // The block may still be clearing its batch after the last result leaves.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stops_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = hold_req;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int                    ph;
    int                    batches;
    int                    n;
    int                    k;
    logic [CFG_DATA_W-1:0] tracks_val;
    logic [TRACK_W-1:0]    t;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 38 : 0;

      if (ph == 0) begin
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd100, 1'b1);
        wait_idle();
        // Zero disk size puts the edge at track zero; a request lies beyond it.
        write_reg(REG_START_HEAD, 17'd65535);
        write_reg(REG_DISK_TRACKS, 17'd0);
        write_reg(REG_SWEEP_RIGHT, 17'd0);
        send_request(16'd5, 1'b0);
        send_request(16'hFFFF, 1'b1);
        wait_idle();
        // All requests below the head, with an oversized disk.
        write_reg(REG_START_HEAD, 17'd30000);
        write_reg(REG_DISK_TRACKS, 17'h1FFFF);
        write_reg(REG_SWEEP_RIGHT, 17'd1);
        send_request(16'd20, 1'b0);
        send_request(16'd10, 1'b1);
        wait_idle();
        write_reg(REG_SWEEP_RIGHT, 17'd0);
        send_request(16'd50000, 1'b0);
        send_request(16'd40000, 1'b1);
        wait_idle();
        // The total seek distance runs past its ceiling.
        write_reg(REG_START_HEAD, 17'd60000);
        write_reg(REG_DISK_TRACKS, 17'd1);
        write_reg(REG_SWEEP_RIGHT, 17'd1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd59999, 1'b0);
        send_request(16'd0, 1'b1);
        wait_idle();
        write_reg(REG_SPARE, 17'h1FFFF);
        write_reg(REG_START_HEAD, 17'd7);
        write_reg(REG_DISK_TRACKS, 17'd65536);
        send_request(16'd7, 1'b0);
        send_request(16'd7, 1'b0);
        send_request(16'd7, 1'b1);
        wait_idle();
        write_reg(REG_SWEEP_RIGHT, 17'd0);
        send_request(16'd7, 1'b1);
      end

      batches = 0;
      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        if (batches % 3 == 0) begin
          wait_idle();
          case ($urandom_range(5))
            0:       tracks_val = '0;
            1:       tracks_val = 17'd1;
            2:       tracks_val = 17'd65536;
            3:       tracks_val = '1;
            4:       tracks_val = CFG_DATA_W'($urandom_range(65536, 1));
            default: tracks_val = CFG_DATA_W'($urandom);
          endcase
          write_reg(REG_DISK_TRACKS, tracks_val);
          case ($urandom_range(3))
            0:       write_reg(REG_START_HEAD, '0);
            1:       write_reg(REG_START_HEAD, 17'h0FFFF);
            default: write_reg(REG_START_HEAD, CFG_DATA_W'($urandom));
          endcase
          write_reg(REG_SWEEP_RIGHT, CFG_DATA_W'($urandom));
        end

        // The long receiver stall fills the block while requests keep coming.
        if (ph == 2 && batches == 1) hold_req++;

        if (batches == 1) n = 34;
        else if ($urandom_range(15) == 0) n = $urandom_range(36, 28);
        else n = $urandom_range(12, 1);

        for (k = 0; k < n; k++) begin
          case ($urandom_range(4))
            0:       t = $urandom_range(1) ? {TRACK_W{1'b1}} : '0;
            1:       t = TRACK_W'(cur_head + $urandom_range(8) - 4);
            2:       t = TRACK_W'($urandom_range(255));
            default: t = TRACK_W'($urandom);
          endcase
          send_request(t, k == n - 1);
        end
        batches++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
